// File: rtl/sha1_pkg.sv
package sha1_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned NUM_WORDS   = 5;
  localparam int unsigned WIN_DEPTH   = 16;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned FILL_W      = 6;
  localparam int unsigned ROUND_W     = 7;
  localparam int unsigned LEN_W       = 64;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - WORD_W - IDX_W;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t IV [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam logic [DATA_W-1:0]  PAD_MARK   = 8'h80;
  localparam logic [DATA_W-1:0]  PAD_ZERO   = 8'h00;
  localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
  localparam logic [FILL_W-1:0]  LEN_START  = 6'd56;
  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;

endpackage

// File: rtl/sha1_stream_hasher_top.sv
// SHA-1 over a byte stream. Each input transfer carries at most one message byte
// (tuser high) and may close the message (tlast high); the digest then leaves as
// five 32-bit words, h0 first, with the word index beside it and tlast on the
// fifth word, after which the hash restarts from the initial values. A plain data
// byte is taken without a stall, except every 64th byte, which starts an 80-round
// compression run one round per cycle on a single shared round adder, followed
// by a step that folds the result into the chaining words. The closing transfer
// feeds the padding and the 64-bit length through the same byte path at one byte
// per cycle while no compression runs, with one or two compressions in all, then
// presents the five digest words, one per cycle while tready is high. Input is
// not taken while a compression, the padding or the digest output is in progress.
module sha1_stream_hasher_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [sha1_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // [7:0] data_byte
  input  logic                                 s_axis_tuser_i,  // [0] has_data
  input  logic                                 s_axis_tlast_i,  // is_last
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [sha1_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,  // [31:0] digest_word,
                                                                // [34:32] word_index,
                                                                // [39:35] zero
  output logic                                 m_axis_tlast_o   // last_word
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } pad_ph_e;

  state_e              state_q;
  pad_ph_e             pad_ph_q;
  logic                last_q;
  logic [COUNT_W-1:0]  count_q;
  logic [FILL_W-1:0]   fill_q;
  logic [ROUND_W-1:0]  round_q;
  logic [2:0]          len_idx_q;
  logic [IDX_W-1:0]    out_idx_q;
  word_t               chain_q [NUM_WORDS];

  word_t               win_q [WIN_DEPTH];
  word_t               a_q, b_q, c_q, d_q, e_q;

  logic                s_fire;
  logic                push_en;
  logic                len_now;
  logic                start_cmp;
  logic [DATA_W-1:0]   push_byte;
  logic [LEN_W-1:0]    len_bits;
  logic [DATA_W-1:0]   len_byte;
  word_t               w_x, w_new, w_t, f_t, k_t, t_sum;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_idx_q, chain_q[0]};
  assign m_axis_tlast_o  = (out_idx_q == LAST_IDX);

  // big-endian bit length, byte 0 is the most significant
  assign len_bits = {count_q, 3'b000};
  assign len_byte = len_bits[{~len_idx_q, 3'b000} +: DATA_W];
  assign len_now  = (pad_ph_q == PH_LEN) || (pad_ph_q == PH_ZERO && fill_q == LEN_START);

  always_comb begin
    push_en   = 1'b0;
    push_byte = s_axis_tdata_i;
    if (state_q == ST_IDLE) begin
      push_en = s_fire && s_axis_tuser_i;
    end else if (state_q == ST_PAD) begin
      push_en = 1'b1;
      if (pad_ph_q == PH_MARK) begin
        push_byte = PAD_MARK;
      end else if (len_now) begin
        push_byte = len_byte;
      end else begin
        push_byte = PAD_ZERO;
      end
    end
  end

  assign start_cmp = push_en && (fill_q == FILL_LAST);

  // message schedule taps on the 16-word window, oldest word at index 0
  assign w_new = {w_x[30:0], w_x[31]};
  assign w_x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign w_t = (round_q < ROUND_W'(WIN_DEPTH)) ? win_q[0] : w_new;

  always_comb begin
    if (round_q inside {[7'd0:7'd19]}) begin
      f_t = (b_q & c_q) | (~b_q & d_q);
      k_t = K_0;
    end else if (round_q inside {[7'd20:7'd39]}) begin
      f_t = b_q ^ c_q ^ d_q;
      k_t = K_1;
    end else if (round_q inside {[7'd40:7'd59]}) begin
      f_t = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_t = K_2;
    end else begin
      f_t = b_q ^ c_q ^ d_q;
      k_t = K_3;
    end
  end

  assign t_sum = {a_q[26:0], a_q[31:27]} + f_t + e_q + k_t + w_t;

  // control and chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pad_ph_q  <= PH_MARK;
      last_q    <= 1'b0;
      count_q   <= '0;
      fill_q    <= '0;
      round_q   <= '0;
      len_idx_q <= '0;
      out_idx_q <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_q[i] <= IV[i];
      end
    end else begin
      if (push_en) begin
        fill_q <= fill_q + 1'b1;
      end
      if (start_cmp) begin
        round_q <= '0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            last_q    <= s_axis_tlast_i;
            pad_ph_q  <= PH_MARK;
            len_idx_q <= '0;
            if (s_axis_tuser_i) begin
              count_q <= count_q + 1'b1;
            end
            if (start_cmp) begin
              state_q <= ST_ROUND;
            end else if (s_axis_tlast_i) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pad_ph_q == PH_MARK) begin
            pad_ph_q <= PH_ZERO;
          end else if (len_now) begin
            pad_ph_q  <= PH_LEN;
            len_idx_q <= len_idx_q + 1'b1;
          end
          if (start_cmp) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          round_q <= round_q + 1'b1;
          if (round_q == LAST_ROUND) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q;
          out_idx_q  <= '0;
          if (last_q && pad_ph_q == PH_LEN) begin
            state_q <= ST_OUT;
          end else if (last_q) begin
            state_q <= ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (m_axis_tready_i) begin
            out_idx_q <= out_idx_q + 1'b1;
            if (out_idx_q == LAST_IDX) begin
              // digest done, start a fresh message
              for (int i = 0; i < NUM_WORDS; i++) begin
                chain_q[i] <= IV[i];
              end
              count_q <= '0;
              last_q  <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              for (int i = 0; i < NUM_WORDS - 1; i++) begin
                chain_q[i] <= chain_q[i+1];
              end
              chain_q[NUM_WORDS-1] <= chain_q[0];
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // block window and working variables
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      // bytes enter at the low end of the 512-bit block, first byte ends up on top
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_q[i] <= {win_q[i][WORD_W-DATA_W-1:0], win_q[i+1][WORD_W-1 -: DATA_W]};
      end
      win_q[WIN_DEPTH-1] <= {win_q[WIN_DEPTH-1][WORD_W-DATA_W-1:0], push_byte};
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WIN_DEPTH-1] <= w_t;
    end

    if (start_cmp) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (state_q == ST_ROUND) begin
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

endmodule

// File: rtl/sha1_chk.sv
module sha1_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_o,
  input  logic [sha1_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tlast_i,
  input  logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic [sha1_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                             m_axis_tlast_o
);
  import sha1_pkg::*;

  logic [IDX_W-1:0] idx;
  assign idx = m_axis_tdata_o[WORD_W +: IDX_W];

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("digest word changed while stalled");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> idx <= LAST_IDX)
    else $error("word index out of range");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (idx == LAST_IDX)))
    else $error("tlast does not match the fifth word");

  // no input is taken while the digest is going out
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready during digest output");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && idx == $past(idx) + 3'd1)
    else $error("digest words out of order");

endmodule

bind sha1_stream_hasher_top sha1_chk u_sha1_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
